/* rtl/core/sscf_pkg.sv */
// ----------------------------------------------------------------------------
// sscf_pkg
// Shared types, codes and constants of the session sequenced freshness cache.
// ----------------------------------------------------------------------------
package sscf_pkg;

	// number of sources tracked, ids run from 1 to SOURCE_COUNT
	localparam int unsigned SOURCE_COUNT = 8;
	localparam int unsigned SRC_IDX_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
	localparam logic [7:0] SRC_MAX = 8'(SOURCE_COUNT);

	// reset value of the freshness window
	localparam logic [31:0] WINDOW_RESET = 32'd1000;

	// operation codes
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_STALE  = 3'd1,
		ST_DUP    = 3'd2,
		ST_KIND   = 3'd3,
		ST_SOURCE = 3'd4
	} status_t;

	// one accepted input transaction
	typedef struct packed {
		logic        operation;
		logic [1:0]  msg_kind;
		logic [7:0]  src_id;
		logic [31:0] session_num;
		logic [31:0] seq_num;
		logic [7:0]  payload_length;
		logic [31:0] time_ms;
		logic [7:0]  request_mask;
	} item_t;

	// contents of one cache slot
	typedef struct packed {
		logic        occupied;
		logic [7:0]  source;
		logic [31:0] session;
		logic [31:0] seq_no;
		logic [31:0] received;
		logic [7:0]  length;
	} slot_t;

	// decision for the item under execution
	typedef struct packed {
		status_t    status;
		logic [1:0] copied;
		logic [1:0] count;
		logic       first_sel;
		logic       sess_wr;
	} eval_t;

	// table index of a source id (id minus one)
	function automatic logic [SRC_IDX_W-1:0] src_index(logic [7:0] src);
		logic [7:0] d;
		d = src - 8'd1;
		return d[SRC_IDX_W-1:0];
	endfunction

endpackage

/* rtl/core/session_sequenced_freshness_cache_top.sv */
// ----------------------------------------------------------------------------
// session_sequenced_freshness_cache_top
// Two-slot freshness cache of decoded messages with per-source session
// tracking; stores are checked and written, queries return fresh slots.
// ----------------------------------------------------------------------------
// Usage:
// - item channel: item_valid with the input fields, taken when item_stall is
//   low. item_stall is high while one transaction is being worked on.
// - result channel: result_valid with the result fields, taken when
//   result_stall is low. A store or an empty query gives one result, a query
//   with two copied slots gives two, the final one marked by last_result.
// - cfg_wr_en writes fresh_window_ms from cfg_wr_data at the clock edge.
// - sequencing: the session memory is read at the accepting edge and the first
//   result is registered when the item commits in execution, as soon as the
//   result register is free; a two-result query loads its second result from
//   the second state. A new item is taken only once the last one is through.
// - reset clears the seen flags, the slots and the result valid flag and
//   loads the window with 1000 ms.
// - while result_stall is high the result is held; one further item may be
//   accepted and waits in execution until the result register frees.
// ----------------------------------------------------------------------------
module session_sequenced_freshness_cache_top
	import sscf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        operation,
	input  logic [1:0]  msg_kind,
	input  logic [7:0]  src_id,
	input  logic [31:0] session_num,
	input  logic [31:0] seq_num,
	input  logic [7:0]  payload_length,
	input  logic [31:0] time_ms,
	input  logic [7:0]  request_mask,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [1:0]  copied_slots,
	output logic        snap_valid,
	output logic        snap_kind,
	output logic [7:0]  snap_source,
	output logic [31:0] snap_session,
	output logic [31:0] snap_sequence,
	output logic [31:0] snap_received,
	output logic [7:0]  snap_length,
	output logic        last_result
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_SECOND = 3'b100
	} state_t;

	state_t      state_q;
	state_t      state_nxt;
	item_t       item_q;
	logic [31:0] window_q;
	logic        second_sel_q;
	logic        accept;
	logic        out_free;
	logic        commit;
	logic        load_second;
	logic        rd_seen;
	logic [31:0] rd_session;
	eval_t       eval;
	slot_t       slot0;
	slot_t       slot1;
	slot_t       first_snap;
	slot_t       second_snap;

	// result register and its payload
	logic        res_valid_q;
	logic [2:0]  status_q;
	logic [1:0]  copied_q;
	logic        snap_valid_q;
	logic        snap_kind_q;
	slot_t       snap_q;
	logic        last_q;

	assign accept      = item_valid && (state_q == S_IDLE);
	assign out_free    = !res_valid_q || !result_stall;
	assign commit      = (state_q == S_EXEC) && out_free;
	assign load_second = (state_q == S_SECOND) && out_free;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	// capture of the accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= '{operation, msg_kind, src_id, session_num, seq_num,
				payload_length, time_ms, request_mask};
		end
	end

	// session memory: read on accept, written back at commit; one item at a
	// time keeps the read and the write of an entry from overlapping
	sscf_session_mem u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_addr    (src_index(src_id)),
		.wr_en      (commit && eval.sess_wr),
		.wr_addr    (src_index(item_q.src_id)),
		.wr_data    (item_q.session_num),
		.rd_seen    (rd_seen),
		.rd_session (rd_session)
	);

	sscf_slots u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_q),
		.rd_seen    (rd_seen),
		.rd_session (rd_session),
		.window     (window_q),
		.commit     (commit),
		.eval       (eval),
		.slot0      (slot0),
		.slot1      (slot1)
	);

	// sequencer
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (commit) state_nxt = (eval.count == 2'd2) ? S_SECOND : S_IDLE;
			end
			S_SECOND: begin
				if (load_second) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// snapshot selection
	assign first_snap  = eval.first_sel ? slot1 : slot0;
	assign second_snap = second_sel_q ? slot1 : slot0;

	always_ff @(posedge clk) begin
		if (commit) begin
			second_sel_q <= !eval.first_sel;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit || load_second) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= eval.status;
			copied_q     <= eval.copied;
			snap_valid_q <= (eval.count != 2'd0);
			snap_kind_q  <= (eval.count != 2'd0) && eval.first_sel;
			snap_q       <= (eval.count != 2'd0) ? first_snap : '0;
			last_q       <= (eval.count != 2'd2);
		end else if (load_second) begin
			snap_kind_q <= second_sel_q;
			snap_q      <= second_snap;
			last_q      <= 1'b1;
		end
	end

	assign item_stall    = (state_q != S_IDLE);
	assign result_valid  = res_valid_q;
	assign status        = status_q;
	assign copied_slots  = copied_q;
	assign snap_valid    = snap_valid_q;
	assign snap_kind     = snap_kind_q;
	assign snap_source   = snap_q.source;
	assign snap_session  = snap_q.session;
	assign snap_sequence = snap_q.seq_no;
	assign snap_received = snap_q.received;
	assign snap_length   = snap_q.length;
	assign last_result   = last_q;

endmodule

/* rtl/core/sscf_session_mem.sv */
// ----------------------------------------------------------------------------
// sscf_session_mem
// Latest-session memory per source with registered read and
// per-entry seen flags cleared by reset.
// ----------------------------------------------------------------------------
module sscf_session_mem
	import sscf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [SRC_IDX_W-1:0] rd_addr,
	input  logic                 wr_en,
	input  logic [SRC_IDX_W-1:0] wr_addr,
	input  logic [31:0]          wr_data,
	output logic                 rd_seen,
	output logic [31:0]          rd_session
);

	logic [31:0]             mem [SOURCE_COUNT];
	logic [SOURCE_COUNT-1:0] seen_q;
	logic                    rd_seen_q;
	logic [31:0]             rd_session_q;

	// session storage, no reset, guarded by seen flags
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_session_q <= mem[rd_addr];
		end
	end

	// seen flags and registered flag read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			rd_seen_q <= 1'b0;
		end else begin
			if (wr_en) begin
				seen_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_seen_q <= seen_q[rd_addr];
			end
		end
	end

	assign rd_seen    = rd_seen_q;
	assign rd_session = rd_session_q;

endmodule

/* rtl/core/sscf_slots.sv */
// ----------------------------------------------------------------------------
// sscf_slots
// Ride and environment slots, store checks against the looked-up session,
// freshness test and result ordering for queries.
// ----------------------------------------------------------------------------
module sscf_slots
	import sscf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        rd_seen,
	input  logic [31:0] rd_session,
	input  logic [31:0] window,
	input  logic        commit,
	output eval_t       eval,
	output slot_t       slot0,
	output slot_t       slot1
);

	slot_t       slot_q [2];
	logic        kind_bad;
	logic        src_bad;
	logic        sel;
	logic        ses_old;
	logic        ses_new;
	logic [1:0]  clr;
	logic        hold;
	logic        lower;
	logic        equal;
	logic        slot_wr;
	logic        mask_ok;
	logic [31:0] age [2];
	logic [1:0]  fresh;
	logic [1:0]  copied;
	logic        swap;

	// store checks
	always_comb begin
		kind_bad = item.msg_kind[1];
		src_bad  = (item.src_id == 8'd0) || (item.src_id > SRC_MAX);
		sel      = item.msg_kind[0];
		ses_old  = rd_seen && (item.session_num < rd_session);
		ses_new  = !rd_seen || (item.session_num > rd_session);
		for (int k = 0; k < 2; k++) begin
			clr[k] = ses_new && slot_q[k].occupied && (slot_q[k].source == item.src_id)
				&& (slot_q[k].session < item.session_num);
		end
		hold  = slot_q[sel].occupied && !clr[sel] && (slot_q[sel].source == item.src_id);
		equal = (item.session_num == slot_q[sel].session)
			&& (item.seq_num == slot_q[sel].seq_no);
		lower = (item.session_num < slot_q[sel].session)
			|| ((item.session_num == slot_q[sel].session)
				&& (item.seq_num < slot_q[sel].seq_no));
	end

	// query freshness under wrapping age
	always_comb begin
		mask_ok = (item.request_mask[1:0] != 2'b00) && (item.request_mask[7:2] == 6'd0);
		for (int k = 0; k < 2; k++) begin
			age[k]    = item.time_ms - slot_q[k].received;
			fresh[k]  = slot_q[k].occupied && (age[k] <= window);
			copied[k] = mask_ok && item.request_mask[k] && fresh[k];
		end
		swap = (copied == 2'b11) && (slot_q[0].source == slot_q[1].source)
			&& (slot_q[0].session == slot_q[1].session)
			&& (slot_q[0].seq_no > slot_q[1].seq_no);
	end

	// decision
	always_comb begin
		eval    = '0;
		slot_wr = 1'b0;
		if (item.operation == OP_STORE) begin
			priority if (kind_bad) begin
				eval.status = ST_KIND;
			end else if (src_bad) begin
				eval.status = ST_SOURCE;
			end else if (ses_old) begin
				eval.status = ST_STALE;
			end else begin
				eval.sess_wr = ses_new;
				if (hold && lower) begin
					eval.status = ST_STALE;
				end else if (hold && equal) begin
					eval.status = ST_DUP;
				end else begin
					eval.status = ST_OK;
					slot_wr     = 1'b1;
				end
			end
		end else begin
			eval.status    = ST_OK;
			eval.copied    = copied;
			eval.count     = {1'b0, copied[0]} + {1'b0, copied[1]};
			eval.first_sel = swap || !copied[0];
		end
	end

	// slot registers: a write loads its slot, a newer session drops older ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q[0] <= '0;
			slot_q[1] <= '0;
		end else if (commit && (item.operation == OP_STORE)) begin
			for (int k = 0; k < 2; k++) begin
				if (slot_wr && (int'(sel) == k)) begin
					slot_q[k] <= '{1'b1, item.src_id, item.session_num, item.seq_num,
						item.time_ms, item.payload_length};
				end else if (eval.sess_wr && clr[k]) begin
					slot_q[k].occupied <= 1'b0;
				end
			end
		end
	end

	assign slot0 = slot_q[0];
	assign slot1 = slot_q[1];

endmodule

/* rtl/core/sscf_checker.sv */
// ----------------------------------------------------------------------------
// sscf_checker
// Port-level checks of the freshness cache, bound to the top level.
// ----------------------------------------------------------------------------
module sscf_checker
	import sscf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [2:0]  status,
	input logic [1:0]  copied_slots,
	input logic        snap_valid,
	input logic        snap_kind,
	input logic [31:0] snap_session,
	input logic        last_result
);

	// an accepted transaction keeps the input side busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after accepted transaction");

	// a held result keeps its contents
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status)
			&& $stable(snap_session) && $stable(last_result))
		else $error("stalled result changed");

	// a result without a snapshot is the only result of its transaction
	a_blank_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !snap_valid |-> last_result && (copied_slots == 2'b00))
		else $error("result without snapshot is not a single final result");

	// a snapshot is always reported as copied with ok status
	a_snap_copied: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && snap_valid |-> (status == ST_OK)
			&& (snap_kind ? copied_slots[1] : copied_slots[0]))
		else $error("snapshot not covered by copied mask");

endmodule

bind session_sequenced_freshness_cache_top sscf_checker u_sscf_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the session sequenced freshness cache. A driver and
// a monitor run on the clock; each accepted transaction is run through a
// behavioral copy of the cache, and every result must match the oldest
// prediction. A directed prologue hits rejections, duplicates, session
// turnover, window edges and result ordering. Random phases then follow
// under different windows and idle or stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import sscf_pkg::*;

	// one cache slot as the bench tracks it
	typedef struct packed {
		logic        occupied;
		logic [7:0]  source;
		logic [31:0] session;
		logic [31:0] seq_no;
		logic [31:0] received;
		logic [7:0]  length;
	} cache_entry_t;

	// one result transaction
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  copied;
		logic        snap_valid;
		logic        snap_kind;
		logic [7:0]  source;
		logic [31:0] session;
		logic [31:0] seq_no;
		logic [31:0] received;
		logic [7:0]  length;
		logic        last;
	} cache_result_t;

	localparam int RANDOM_PER_PHASE = 206;
	localparam int PHASES = 5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        operation = 1'b0;
	logic [1:0]  msg_kind = '0;
	logic [7:0]  src_id = '0;
	logic [31:0] session_num = '0;
	logic [31:0] seq_num = '0;
	logic [7:0]  payload_length = '0;
	logic [31:0] time_ms = '0;
	logic [7:0]  request_mask = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  status;
	logic [1:0]  copied_slots;
	logic        snap_valid;
	logic        snap_kind;
	logic [7:0]  snap_source;
	logic [31:0] snap_session;
	logic [31:0] snap_sequence;
	logic [31:0] snap_received;
	logic [7:0]  snap_length;
	logic        last_result;

	// predicted cache state
	logic [31:0]   window_ms = WINDOW_RESET;
	logic [31:0]   newest_ses [SOURCE_COUNT];
	bit            ses_known [SOURCE_COUNT];
	cache_entry_t  cache_slot [2];

	// stimulus and expectation stores
	item_t         pending_items [$];
	cache_result_t expected_results [$];
	item_t         shown_item;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            errors = 0;

	// generator bookkeeping for well-formed sequences
	logic [31:0]   gen_session [SOURCE_COUNT];
	logic [31:0]   gen_seq [SOURCE_COUNT];
	logic [31:0]   gen_now = '0;
	logic [31:0]   last_store_time [2];

	session_sequenced_freshness_cache_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.operation      (operation),
		.msg_kind       (msg_kind),
		.src_id         (src_id),
		.session_num    (session_num),
		.seq_num        (seq_num),
		.payload_length (payload_length),
		.time_ms        (time_ms),
		.request_mask   (request_mask),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.copied_slots   (copied_slots),
		.snap_valid     (snap_valid),
		.snap_kind      (snap_kind),
		.snap_source    (snap_source),
		.snap_session   (snap_session),
		.snap_sequence  (snap_sequence),
		.snap_received  (snap_received),
		.snap_length    (snap_length),
		.last_result    (last_result)
	);

	always #5 clk = ~clk;

	// readable dump of one result
	function automatic string describe(cache_result_t r);
		return $sformatf(
			"st=%0d copied=%0d sv=%0d sk=%0d src=%0d ses=%h seq=%h rx=%h len=%0d last=%0d",
			r.status, r.copied, r.snap_valid, r.snap_kind, r.source, r.session, r.seq_no,
			r.received, r.length, r.last);
	endfunction

	function automatic void note_failure(string what, cache_result_t want, cache_result_t got);
		errors++;
		if (errors <= 10)
			$display("%0t mismatch: %s\n  expected %s\n  actual   %s", $realtime, what,
				describe(want), describe(got));
	endfunction

	// store check: kind, source, session, then slot ordering
	function automatic logic [2:0] cache_store(item_t it);
		int   idx;
		int   k;
		logic s;
		if (it.msg_kind > 2'd1) return ST_KIND;
		if (it.src_id == 8'd0 || it.src_id > SRC_MAX) return ST_SOURCE;
		idx = int'(it.src_id) - 1;
		if (ses_known[idx] && it.session_num < newest_ses[idx]) return ST_STALE;
		// newer session drops older snapshots of the same source
		if (!ses_known[idx] || it.session_num > newest_ses[idx]) begin
			newest_ses[idx] = it.session_num;
			ses_known[idx] = 1'b1;
			for (k = 0; k < 2; k++)
				if (cache_slot[k].occupied && cache_slot[k].source == it.src_id &&
						cache_slot[k].session < it.session_num)
					cache_slot[k] = '0;
		end
		s = it.msg_kind[0];
		if (cache_slot[s].occupied && cache_slot[s].source == it.src_id) begin
			if (it.session_num < cache_slot[s].session ||
					(it.session_num == cache_slot[s].session && it.seq_num < cache_slot[s].seq_no))
				return ST_STALE;
			if (it.session_num == cache_slot[s].session && it.seq_num == cache_slot[s].seq_no)
				return ST_DUP;
		end
		cache_slot[s] = '{1'b1, it.src_id, it.session_num, it.seq_num, it.time_ms,
			it.payload_length};
		return ST_OK;
	endfunction

	function automatic bit slot_is_fresh(int k, logic [31:0] now);
		logic [31:0] age;
		age = now - cache_slot[k].received;
		return cache_slot[k].occupied && age <= window_ms;
	endfunction

	// expected results of one accepted transaction
	function automatic void predict_results(item_t it);
		cache_result_t r;
		int            order [2];
		int            n;
		int            k;
		logic [1:0]    copied;
		r = '0;
		n = 0;
		copied = '0;
		if (it.operation == OP_STORE) begin
			r.status = cache_store(it);
			r.last = 1'b1;
			expected_results.push_back(r);
			return;
		end
		if (it.request_mask != 8'd0 && it.request_mask[7:2] == 6'd0) begin
			if (it.request_mask[0] && slot_is_fresh(0, it.time_ms)) begin
				order[n] = 0;
				n++;
				copied[0] = 1'b1;
			end
			if (it.request_mask[1] && slot_is_fresh(1, it.time_ms)) begin
				order[n] = 1;
				n++;
				copied[1] = 1'b1;
			end
		end
		// same source and session: lower sequence goes out first
		if (n == 2 && cache_slot[0].source == cache_slot[1].source &&
				cache_slot[0].session == cache_slot[1].session &&
				cache_slot[0].seq_no > cache_slot[1].seq_no) begin
			order[0] = 1;
			order[1] = 0;
		end
		if (n == 0) begin
			r.last = 1'b1;
			expected_results.push_back(r);
			return;
		end
		for (k = 0; k < n; k++) begin
			r.status = ST_OK;
			r.copied = copied;
			r.snap_valid = 1'b1;
			r.snap_kind = order[k][0];
			r.source = cache_slot[order[k]].source;
			r.session = cache_slot[order[k]].session;
			r.seq_no = cache_slot[order[k]].seq_no;
			r.received = cache_slot[order[k]].received;
			r.length = cache_slot[order[k]].length;
			r.last = (k == n - 1);
			expected_results.push_back(r);
		end
	endfunction

	function automatic item_t make_item(logic op, logic [1:0] kind, logic [7:0] src,
			logic [31:0] ses, logic [31:0] seq, logic [7:0] len, logic [31:0] now,
			logic [7:0] mask);
		item_t it;
		it.operation = op;
		it.msg_kind = kind;
		it.src_id = src;
		it.session_num = ses;
		it.seq_num = seq;
		it.payload_length = len;
		it.time_ms = now;
		it.request_mask = mask;
		return it;
	endfunction

	// random transaction, mostly well-formed session and sequence progressions
	function automatic item_t random_item();
		item_t       it;
		int          idx;
		int          roll;
		logic [31:0] offset;
		it = make_item($urandom_range(99) < 35 ? OP_QUERY : OP_STORE, 2'($urandom),
			8'($urandom), $urandom, $urandom, 8'($urandom), $urandom, 8'($urandom));
		gen_now = gen_now + $urandom_range(0, 40);
		if (it.operation == OP_STORE) begin
			if ($urandom_range(9) != 0) it.msg_kind = 2'($urandom_range(1));
			roll = $urandom_range(19);
			if (roll < 12) it.src_id = 8'($urandom_range(1, 3));
			else if (roll < 17) it.src_id = 8'($urandom_range(1, SOURCE_COUNT));
			if (it.src_id >= 8'd1 && it.src_id <= SRC_MAX) begin
				idx = int'(it.src_id) - 1;
				roll = $urandom_range(99);
				if (roll < 20) begin
					gen_session[idx] = gen_session[idx] + 1;
					gen_seq[idx] = $urandom_range(0, 3);
				end else if (roll < 24) begin
					gen_session[idx] = $urandom;
					gen_seq[idx] = $urandom_range(0, 3);
				end
				it.session_num = gen_session[idx];
				if (roll >= 85 && roll < 95) it.session_num = gen_session[idx] - 1;
				roll = $urandom_range(99);
				if (roll < 50) gen_seq[idx] = gen_seq[idx] + 1;
				else if (roll < 95 && roll >= 85) gen_seq[idx] = $urandom_range(0, 15);
				else if (roll >= 95) gen_seq[idx] = $urandom;
				it.seq_num = gen_seq[idx];
				if (roll >= 70 && roll < 85) it.seq_num = gen_seq[idx] - $urandom_range(1, 3);
			end
			if ($urandom_range(19) != 0) it.time_ms = gen_now;
			last_store_time[it.msg_kind[0]] = it.time_ms;
		end else begin
			if ($urandom_range(4) != 0) it.request_mask = 8'($urandom_range(1, 3));
			case ($urandom_range(4))
				0: offset = '0;
				1: offset = window_ms;
				2: offset = window_ms + 1;
				3: offset = $urandom_range(0, 3000);
				default: offset = $urandom;
			endcase
			it.time_ms = last_store_time[$urandom_range(1)] + offset;
		end
		return it;
	endfunction

	// driver: offers queued transactions, predicts on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				predict_results(shown_item);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					shown_item = pending_items.pop_front();
					item_valid <= 1'b1;
					operation <= shown_item.operation;
					msg_kind <= shown_item.msg_kind;
					src_id <= shown_item.src_id;
					session_num <= shown_item.session_num;
					seq_num <= shown_item.seq_num;
					payload_length <= shown_item.payload_length;
					time_ms <= shown_item.time_ms;
					request_mask <= shown_item.request_mask;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random stall, compare every accepted result
	always @(posedge clk) begin : watch
		cache_result_t got;
		cache_result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				got = '{status, copied_slots, snap_valid, snap_kind, snap_source, snap_session,
					snap_sequence, snap_received, snap_length, last_result};
				if (expected_results.size() == 0) begin
					note_failure("result with nothing pending", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) note_failure("field difference", want, got);
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// wait until nothing is queued, offered or outstanding
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_window(logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		window_ms = value;
	endtask

	initial begin
		int          send_pct [PHASES];
		int          stall_pct [PHASES];
		logic [31:0] windows [PHASES];
		int          left;
		int          chunk;
		send_pct = '{0, 76, 0, 30, 0};
		stall_pct = '{0, 0, 76, 30, 0};
		windows = '{32'd0, 32'hFFFF_FFFF, 32'($urandom_range(1, 5000)), 32'd1000,
			32'h8000_0000};
		for (int i = 0; i < SOURCE_COUNT; i++) begin
			newest_ses[i] = '0;
			ses_known[i] = 1'b0;
			gen_session[i] = '0;
			gen_seq[i] = '0;
		end
		cache_slot[0] = '0;
		cache_slot[1] = '0;
		last_store_time[0] = '0;
		last_store_time[1] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed prologue under the reset window
		@(negedge clk);
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, '0, 8'd3));
		pending_items.push_back(make_item(OP_STORE, 2'd2, 8'd1, '0, '0, 8'd7, 32'd10, 8'd0));
		pending_items.push_back(make_item(OP_STORE, 2'd3, 8'd1, '0, '0, 8'd7, 32'd10, 8'hFF));
		pending_items.push_back(make_item(OP_STORE, 2'd0, 8'd0, 32'd1, '0, 8'd7, 32'd10,
			8'd0));
		pending_items.push_back(make_item(OP_STORE, 2'd0, 8'd9, 32'd1, '0, 8'd7, 32'd10,
			8'd0));
		pending_items.push_back(make_item(OP_STORE, 2'd1, 8'd255, 32'd1, '0, 8'd7, 32'd10,
			8'd0));
		pending_items.push_back(make_item(OP_STORE, 2'd0, 8'd1, 32'd5, 32'd10, 8'd255,
			32'd100, 8'd0));
		pending_items.push_back(make_item(OP_STORE, 2'd1, 8'd1, 32'd5, 32'd3, 8'd0,
			32'd200, 8'd0));
		// same source and session, ride sequence higher: environment first
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'd300,
			8'd3));
		pending_items.push_back(make_item(OP_STORE, 2'd0, 8'd1, 32'd5, 32'd10, 8'd1,
			32'd310, 8'd0));
		pending_items.push_back(make_item(OP_STORE, 2'd0, 8'd1, 32'd5, 32'd9, 8'd1,
			32'd320, 8'd0));
		pending_items.push_back(make_item(OP_STORE, 2'd0, 8'd1, 32'd4, 32'd99, 8'd1,
			32'd330, 8'd0));
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'd340,
			8'd0));
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'd340,
			8'd4));
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'd340,
			8'hFF));
		// window edges: age equal to the window is fresh, one more is not
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'd1100,
			8'd1));
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'd1101,
			8'd1));
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'd1200,
			8'd2));
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'd1201,
			8'd2));
		// newer session clears both slots, then age across the 32-bit wrap
		pending_items.push_back(make_item(OP_STORE, 2'd1, 8'd1, 32'd6, 32'd0, 8'd9,
			32'hFFFF_FFF0, 8'd0));
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'h10, 8'd3));
		pending_items.push_back(make_item(OP_STORE, 2'd0, 8'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			8'd255, 32'hFFFF_FFFF, 8'd0));
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'd5, 8'd3));
		pending_items.push_back(make_item(OP_STORE, 2'd0, 8'd2, 32'd0, 32'd0, 8'd0, 32'd0,
			8'd0));
		pending_items.push_back(make_item(OP_QUERY, 2'd0, 8'd0, '0, '0, 8'd0, 32'd0, 8'd1));
		gen_now = 32'd400;
		last_store_time[0] = 32'd0;
		last_store_time[1] = 32'hFFFF_FFF0;
		wait_drained();

		// random phases, drained between chunks so the sender pauses often
		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = send_pct[p];
			recv_stall_pct = stall_pct[p];
			write_window(windows[p]);
			if (p == 4) gen_now = 32'hFFFF_F000;
			left = RANDOM_PER_PHASE;
			while (left > 0) begin
				chunk = $urandom_range(20, 60);
				if (chunk > left) chunk = left;
				@(negedge clk);
				repeat (chunk) pending_items.push_back(random_item());
				left -= chunk;
				wait_drained();
			end
		end

		repeat (6) @(posedge clk);
		errors += expected_results.size();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
